/* hdl/afcp_pkg.sv */
`default_nettype none

package afcp_pkg;

    // Frame limits
    localparam int FRAME_BYTES = 32;
    localparam int CNT_W       = $clog2(FRAME_BYTES);
    localparam int NUM_FIELDS  = 4;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int ACC_W  = 16;
    localparam int VAL_W  = 12;
    localparam int FLD_W  = 3;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_START = 8'h40;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam logic [VAL_W-1:0] VAL_MAX = 12'd4095;

    // One result transaction
    typedef struct packed {
        logic [VAL_W-1:0] channel_a;
        logic [VAL_W-1:0] channel_b;
        logic [VAL_W-1:0] channel_c;
        logic [VAL_W-1:0] channel_d;
    } t_result;

    // Clamp an accumulated value to the channel range
    function automatic logic [VAL_W-1:0] clamp_value(input logic [ACC_W-1:0] v);
        logic [VAL_W-1:0] r;
        if (v > ACC_W'(VAL_MAX)) begin
            r = VAL_MAX;
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/afcp_if.sv */
`default_nettype none

// Received byte channel
interface afcp_rx_if;
    import afcp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Parsed command channel
interface afcp_res_if;
    import afcp_pkg::*;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] channel_a;
    logic [VAL_W-1:0] channel_b;
    logic [VAL_W-1:0] channel_c;
    logic [VAL_W-1:0] channel_d;

    modport source (output valid, output channel_a, output channel_b,
                    output channel_c, output channel_d, input ready);
    modport sink   (input valid, input channel_a, input channel_b,
                    input channel_c, input channel_d, output ready);
endinterface

`default_nettype wire

/* hdl/ascii_four_field_command_parser_core.sv */
`default_nettype none

// Parser for ASCII command frames "@a,b,c,d" ended by LF. Bytes arrive on i_rx,
// one transaction per cycle while results are taken; each byte passes an input
// register and its outcome lands in the result register, so o_res.valid rises
// once its LF has passed both. Bytes before '@' are ignored, a frame whose
// 32nd byte after '@' is not LF is dropped, and a result is given only when
// at least four comma-separated fields were seen; the first four are kept,
// each wrapped at 16 bits and then clamped to 4095. i_rx.ready follows
// o_res.ready in the same cycle while a result is waiting and a byte is held;
// a stalled result stalls parsing one byte later.
module ascii_four_field_command_parser_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    afcp_rx_if.sink     i_rx,
    afcp_res_if.source  o_res
);
    import afcp_pkg::*;

    logic    res_load;
    logic    out_free;
    t_result res;

    afcp_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx.valid),
        .i_rx_byte  (i_rx.rx_byte),
        .o_rx_ready (i_rx.ready),
        .i_out_free (out_free),
        .o_res_load (res_load),
        .o_res      (res)
    );

    afcp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_load),
        .i_res   (res),
        .o_free  (out_free),
        .o_res   (o_res)
    );

    // A result is produced only when the result register can take it
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> out_free)
        else $error("result produced while result register is stalled");

    // A taken result with nothing new behind it empties the register
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && !res_load) |=> !o_res.valid)
        else $error("result repeated after being taken");

    // A new result always shows up in the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |=> o_res.valid)
        else $error("produced result lost");

endmodule

`default_nettype wire

/* hdl/afcp_parser.sv */
`default_nettype none

module afcp_parser (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_rx_valid,
    input  wire logic [afcp_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                        o_rx_ready,
    input  wire logic                   i_out_free,
    output logic                        o_res_load,
    output afcp_pkg::t_result           o_res
);
    import afcp_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    logic              r_in_frame, n_in_frame;
    logic [CNT_W-1:0]  r_count,    n_count;
    logic [FLD_W-1:0]  r_fields,   n_fields;
    logic [ACC_W-1:0]  r_acc,      n_acc;
    logic              r_dseen,    n_dseen;
    logic [VAL_W-1:0]  r_store [NUM_FIELDS];
    logic [VAL_W-1:0]  n_store [NUM_FIELDS];

    logic advance;
    logic accept;
    logic found;

    // Advance the held byte when the result register can take its outcome
    assign advance    = r_in_valid && i_out_free;
    assign o_rx_ready = !r_in_valid || advance;
    assign accept     = i_rx_valid && o_rx_ready;

    // Parse one byte against the frame state
    always_comb begin
        n_in_frame = r_in_frame;
        n_count    = r_count;
        n_fields   = r_fields;
        n_acc      = r_acc;
        n_dseen    = r_dseen;
        n_store    = r_store;
        found      = 1'b0;

        if (advance) begin
            if (!r_in_frame) begin
                if (r_in_byte == CH_START) begin
                    n_in_frame = 1'b1;
                    n_count    = '0;
                    n_fields   = '0;
                    n_acc      = '0;
                    n_dseen    = 1'b0;
                end
            end else if (r_in_byte == CH_LF) begin
                // close a pending field, report only a full set of four
                n_in_frame = 1'b0;
                if (r_dseen && r_fields < FLD_W'(NUM_FIELDS)) begin
                    n_store[r_fields[1:0]] = clamp_value(r_acc);
                    n_fields               = r_fields + FLD_W'(1);
                end
                found = (n_fields == FLD_W'(NUM_FIELDS));
            end else if (r_count >= CNT_W'(FRAME_BYTES - 1)) begin
                // drop an overlong frame
                n_in_frame = 1'b0;
            end else begin
                n_count = r_count + CNT_W'(1);
                if (r_in_byte inside {[CH_ZERO:CH_NINE]}) begin
                    n_acc   = {r_acc[ACC_W-4:0], 3'b000} + {r_acc[ACC_W-2:0], 1'b0}
                            + {{(ACC_W-4){1'b0}}, r_in_byte[3:0]};
                    n_dseen = 1'b1;
                end else if (r_in_byte == CH_COMMA) begin
                    if (r_fields < FLD_W'(NUM_FIELDS)) begin
                        n_store[r_fields[1:0]] = clamp_value(r_acc);
                        n_fields               = r_fields + FLD_W'(1);
                    end
                    n_acc   = '0;
                    n_dseen = 1'b0;
                end
            end
        end
    end

    assign o_res_load     = found;
    assign o_res.channel_a = n_store[0];
    assign o_res.channel_b = n_store[1];
    assign o_res.channel_c = n_store[2];
    assign o_res.channel_d = n_store[3];

    // Hold the input byte and the frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_fields   <= '0;
            r_acc      <= '0;
            r_dseen    <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_fields   <= n_fields;
            r_acc      <= n_acc;
            r_dseen    <= n_dseen;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_rx_byte;
        end
        r_store <= n_store;
    end

endmodule

`default_nettype wire

/* hdl/afcp_out_reg.sv */
`default_nettype none

module afcp_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire afcp_pkg::t_result i_res,
    output logic                   o_free,
    afcp_res_if.source             o_res
);
    import afcp_pkg::*;

    logic    r_valid;
    t_result r_data;

    // Free when empty or when the held transaction leaves this cycle
    assign o_free = !r_valid || o_res.ready;

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_res;
        end
    end

    assign o_res.valid     = r_valid;
    assign o_res.channel_a = r_data.channel_a;
    assign o_res.channel_b = r_data.channel_b;
    assign o_res.channel_c = r_data.channel_c;
    assign o_res.channel_d = r_data.channel_d;

endmodule

`default_nettype wire

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import afcp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 420;
    localparam int DEC_BASE     = 10;
    localparam int NUM_ROWS     = 26;

    // How a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_CMD
    } t_chk;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        t_chk              chk;
        t_result           cmd;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    afcp_rx_if  rx_if ();
    afcp_res_if res_if ();

    ascii_four_field_command_parser_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    // Parser model state
    logic              frm_open    = 1'b0;
    int                frm_len     = 0;
    logic [FLD_W-1:0]  fields_kept = '0;
    logic [ACC_W-1:0]  digit_acc   = '0;
    logic              has_digits  = 1'b0;
    logic [VAL_W-1:0]  field_val [NUM_FIELDS];

    t_result           pending_cmds [$];
    logic [BYTE_W-1:0] frame_q [$];
    int                mismatch_cnt   = 0;
    int                busy_items     = 0;
    int                cycle_cnt      = 0;
    int                snd_idle_pct   = 0;
    int                rcv_idle_pct   = 0;
    logic              stall_hold     = 1'b0;
    bit                hold_go        = 1'b0;

    // Directed frames: idle noise, a full frame with empty field, wrap, clamp,
    // '@' and CR inside, a fifth field and pending digits, then a short frame
    t_stim_row directed_rows [NUM_ROWS] = '{
        '{8'hFF,    CHK_NONE,  '0},
        '{CH_LF,    CHK_NONE,  '0},
        '{CH_START, CHK_MODEL, '0},
        '{CH_COMMA, CHK_MODEL, '0},
        '{"6",      CHK_MODEL, '0},
        '{"5",      CHK_MODEL, '0},
        '{"5",      CHK_MODEL, '0},
        '{"3",      CHK_MODEL, '0},
        '{"6",      CHK_MODEL, '0},
        '{CH_COMMA, CHK_MODEL, '0},
        '{"9",      CHK_MODEL, '0},
        '{"9",      CHK_MODEL, '0},
        '{"9",      CHK_MODEL, '0},
        '{"9",      CHK_MODEL, '0},
        '{CH_COMMA, CHK_MODEL, '0},
        '{CH_START, CHK_MODEL, '0},
        '{CH_CR,    CHK_MODEL, '0},
        '{"0",      CHK_MODEL, '0},
        '{CH_COMMA, CHK_MODEL, '0},
        '{"7",      CHK_MODEL, '0},
        '{CH_COMMA, CHK_MODEL, '0},
        '{"8",      CHK_MODEL, '0},
        '{CH_LF,    CHK_CMD,   '{12'd0, 12'd0, 12'd4095, 12'd0}},
        '{CH_START, CHK_MODEL, '0},
        '{"1",      CHK_MODEL, '0},
        '{CH_LF,    CHK_NONE,  '0}
    };

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Close the running field while fewer than four are kept
    function automatic void close_field();
        if (fields_kept < NUM_FIELDS) begin
            field_val[fields_kept[1:0]] = (digit_acc > ACC_W'(VAL_MAX)) ? VAL_MAX
                                                                        : digit_acc[VAL_W-1:0];
            fields_kept++;
        end
    endfunction

    // Advance the parser by one byte; return 1 when a command comes out
    function automatic bit parse_rx_byte(input logic [BYTE_W-1:0] b, output t_result cmd);
        cmd = '0;
        if (!frm_open) begin
            if (b == CH_START) begin
                frm_open    = 1'b1;
                frm_len     = 0;
                fields_kept = '0;
                digit_acc   = '0;
                has_digits  = 1'b0;
            end
            return 1'b0;
        end
        if (b == CH_LF) begin
            frm_open = 1'b0;
            if (has_digits) close_field();
            if (fields_kept == NUM_FIELDS) begin
                cmd = '{field_val[0], field_val[1], field_val[2], field_val[3]};
                return 1'b1;
            end
            return 1'b0;
        end
        // Drop the frame on overflow
        if (frm_len >= FRAME_BYTES - 1) begin
            frm_open = 1'b0;
            return 1'b0;
        end
        frm_len++;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            digit_acc  = ACC_W'(digit_acc * DEC_BASE + (b - CH_ZERO));
            has_digits = 1'b1;
        end else if (b == CH_COMMA) begin
            close_field();
            digit_acc  = '0;
            has_digits = 1'b0;
        end
        return 1'b0;
    endfunction

    // Offer one byte, wait for the transaction, then predict its outcome
    task automatic send_byte(input logic [BYTE_W-1:0] b, input t_chk chk, input t_result cmd);
        t_result predicted;
        bit      has_cmd;
        while ($urandom_range(99) < snd_idle_pct) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        if (frm_open || b == CH_START) busy_items++;
        has_cmd = parse_rx_byte(b, predicted);
        case (chk)
            CHK_MODEL: if (has_cmd) pending_cmds.push_back(predicted);
            CHK_CMD:   pending_cmds.push_back(cmd);
            default: ;
        endcase
    endtask

    function automatic logic [BYTE_W-1:0] noise_byte();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(255)); while (b == CH_LF);
        return b;
    endfunction

    function automatic string field_text();
        case ($urandom_range(7))
            0:       return "";
            1:       return $sformatf("%0d", $urandom_range(4096, 4094));
            2:       return $sformatf("%0d", $urandom_range(65540, 65530));
            3:       return $sformatf("%0d", $urandom_range(99999));
            4:       return $sformatf("00%0d", $urandom_range(999));
            default: return $sformatf("%0d", $urandom_range(4095));
        endcase
    endfunction

    // Build one random sequence of bytes: mostly well-formed frames
    task automatic build_frame();
        int    kind;
        int    nfld;
        int    len;
        string s;
        frame_q.delete();
        kind = $urandom_range(99);
        if (kind < 80) begin
            // Framed: four fields, a random count, or no LF at all
            nfld = (kind < 60) ? NUM_FIELDS : $urandom_range(6);
            frame_q.push_back(CH_START);
            for (int f = 0; f < nfld; f++) begin
                if (f != 0) frame_q.push_back(CH_COMMA);
                if ($urandom_range(9) == 0) frame_q.push_back(noise_byte());
                s = field_text();
                for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
            end
            if ($urandom_range(3) == 0) frame_q.push_back(CH_CR);
            if (kind < 75) frame_q.push_back(CH_LF);
        end else if (kind < 90) begin
            // Length around the overflow boundary
            len = $urandom_range(36, 28);
            frame_q.push_back(CH_START);
            for (int f = 1; f < NUM_FIELDS; f++) begin
                frame_q.push_back(CH_ZERO + BYTE_W'(f));
                frame_q.push_back(CH_COMMA);
            end
            for (int i = 6; i < len; i++) frame_q.push_back(CH_ZERO + BYTE_W'($urandom_range(9)));
            frame_q.push_back(CH_LF);
        end else begin
            // Noise, usually between frames
            len = $urandom_range(6, 1);
            for (int i = 0; i < len; i++) frame_q.push_back(BYTE_W'($urandom_range(255)));
        end
    endtask

    // Result ready, with random stalls and a long hold
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= !stall_hold && ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Hold off results for a long stretch so the input backs up
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        stall_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        stall_hold <= 1'b0;
    end

    task automatic check_channel(input string name, input logic [VAL_W-1:0] want,
                                 input logic [VAL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_cnt++;
        end
    endtask

    // Compare each result transaction with the oldest expected command
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_cmds.size() == 0) begin
                $error("unexpected command: %0d %0d %0d %0d", res_if.channel_a,
                       res_if.channel_b, res_if.channel_c, res_if.channel_d);
                mismatch_cnt++;
            end else begin
                want = pending_cmds.pop_front();
                check_channel("channel_a", want.channel_a, res_if.channel_a);
                check_channel("channel_b", want.channel_b, res_if.channel_b);
                check_channel("channel_c", want.channel_c, res_if.channel_c);
                check_channel("channel_d", want.channel_d, res_if.channel_d);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL ascii_four_field_command_parser_core");
            $finish;
        end
    end

    initial begin : stimulus
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        i_rst_n       = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (directed_rows[r]) begin
            send_byte(directed_rows[r].ch, directed_rows[r].chk, directed_rows[r].cmd);
        end

        // Random frames in three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    snd_idle_pct = 32;
                    rcv_idle_pct <= 58;
                end
                1: begin
                    snd_idle_pct = 58;
                    rcv_idle_pct <= 32;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct <= 0;
                    hold_go = 1'b1;
                end
            endcase
            while (busy_items < (ph + 1) * PHASE_ITEMS) begin
                build_frame();
                foreach (frame_q[i]) send_byte(frame_q[i], CHK_MODEL, '0);
            end
        end
        rx_if.valid <= 1'b0;

        // Drain
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("PASS ascii_four_field_command_parser_core");
        end else begin
            $display("FAIL ascii_four_field_command_parser_core");
        end
        $finish;
    end

endmodule
